### rtl/substring_find_replace_top_macros.svh
// Assertion macros for the substring find and replace block.
// Taken in by the top level; no other dependencies.
`ifndef SUBSTRING_FIND_REPLACE_TOP_MACROS_SVH
`define SUBSTRING_FIND_REPLACE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define SFR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfr assertion failed");
// Next-cycle implication.
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfr assertion failed");
`else
`define SFR_ASSERT_IMP(label, clk, rst, ante, cons)
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/sfr_pkg.sv
// Shared types and constants of the substring find and replace block.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package sfr_pkg;

   localparam int unsigned MAX_PATTERN_DEF = 8;

   // Configuration register indexes
   localparam logic [7:0] CSR_OLD_PATTERN = 8'd0;
   localparam logic [7:0] CSR_OLD_LENGTH  = 8'd1;
   localparam logic [7:0] CSR_NEW_PATTERN = 8'd2;
   localparam logic [7:0] CSR_NEW_LENGTH  = 8'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPLACE,
      ST_FLUSH,
      ST_CLOSE
   } state_type;

   typedef struct packed {
      logic load;          // take the input byte into the held buffer
      logic emit_front;    // emit the oldest held byte and shift it out
      logic emit_rep;      // emit the next replacement byte
      logic finish_match;  // drop the matched bytes, count the match
      logic emit_close;    // emit the closing result with the count
   } cmd_type;

   typedef struct packed {
      logic prefix_ok;     // held bytes are a pattern prefix
      logic full_match;    // held count reached the pattern length
      logic held_empty;
      logic held_full;
      logic end_flag;      // last accepted byte closed the text
      logic rep_done;      // every replacement byte emitted
      logic out_free;      // output register can take a result
   } sts_type;

   function automatic logic [7:0] byte_at(input logic [63:0] word, input logic [2:0] idx);
      return word[{idx, 3'b000} +: 8];
   endfunction

endpackage

`default_nettype wire

### rtl/sfr_ctrl.sv
// Controller state machine of the substring find and replace block.
// Depends on sfr_pkg; drives commands to sfr_dpath from its status.
`default_nettype none

module sfr_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  sfr_pkg::sts_type sts,
   output sfr_pkg::cmd_type cmd
);
   import sfr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.full_match && sts.prefix_ok) begin
               state_in = ST_REPLACE;
            end else if (sts.prefix_ok) begin
               state_in = sts.end_flag ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_REPLACE: begin
            if (sts.rep_done) state_in = ST_SCAN;
         end
         ST_FLUSH: begin
            if (sts.held_empty) state_in = ST_CLOSE;
         end
         ST_CLOSE: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SCAN: begin
            if (!sts.prefix_ok && sts.out_free) cmd.emit_front = 1'b1;
         end
         ST_REPLACE: begin
            if (sts.rep_done) begin
               cmd.finish_match = 1'b1;
            end else if (sts.out_free) begin
               cmd.emit_rep = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (!sts.held_empty && sts.out_free) cmd.emit_front = 1'b1;
         end
         ST_CLOSE: begin
            cmd.emit_close = sts.out_free;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

### rtl/sfr_dpath.sv
// Datapath of the substring find and replace block: configuration registers,
// held byte buffer, counters and the output register. Depends on sfr_pkg.
`default_nettype none

module sfr_dpath #(
   parameter int unsigned MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  sfr_pkg::cmd_type cmd,
   output sfr_pkg::sts_type sts,
   input  logic [7:0]       req_tdata,
   input  logic             req_tlast,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_index,
   input  logic [63:0]      csr_data,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [23:0]      rsp_tdata,
   output logic [0:0]       rsp_tuser,
   output logic             rsp_tlast
);
   import sfr_pkg::*;

   localparam int unsigned   CNT_W   = $clog2(MAX_PATTERN + 1);
   localparam logic [3:0]     MAX_LEN = 4'(MAX_PATTERN);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PATTERN);

   logic [63:0] old_pattern_ff, old_pattern_in;
   logic [3:0]  old_length_ff, old_length_in;
   logic [63:0] new_pattern_ff, new_pattern_in;
   logic [3:0]  new_length_ff, new_length_in;
   logic        csr_hit;

   logic [7:0]       held_ff [MAX_PATTERN];
   logic [7:0]       held_in [MAX_PATTERN];
   logic [CNT_W-1:0] held_count_ff, held_count_in;
   logic [CNT_W-1:0] rep_idx_ff, rep_idx_in;
   logic [15:0]      total_ff, total_in;
   logic             end_ff, end_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_bvalid_ff, rsp_bvalid_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [15:0]      rsp_count_ff, rsp_count_in;

   logic [CNT_W-1:0] plen, rlen;
   logic             prefix_ok, out_free, emit;

   assign csr_ready = 1'b1;

   // Configuration decode; any write to a listed index drops the held bytes
   always_comb begin
      old_pattern_in = old_pattern_ff;
      old_length_in  = old_length_ff;
      new_pattern_in = new_pattern_ff;
      new_length_in  = new_length_ff;
      csr_hit        = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_OLD_PATTERN: begin old_pattern_in = csr_data;      csr_hit = 1'b1; end
            CSR_OLD_LENGTH:  begin old_length_in  = csr_data[3:0]; csr_hit = 1'b1; end
            CSR_NEW_PATTERN: begin new_pattern_in = csr_data;      csr_hit = 1'b1; end
            CSR_NEW_LENGTH:  begin new_length_in  = csr_data[3:0]; csr_hit = 1'b1; end
            default: ;
         endcase
      end
   end

   // Clamp lengths into the supported range
   always_comb begin
      if (old_length_ff == 4'd0) begin
         plen = CNT_W'(1);
      end else if (old_length_ff > MAX_LEN) begin
         plen = MAX_CNT;
      end else begin
         plen = CNT_W'(old_length_ff);
      end
      if (new_length_ff > MAX_LEN) begin
         rlen = MAX_CNT;
      end else begin
         rlen = CNT_W'(new_length_ff);
      end
   end

   // Compare every held position against the pattern in parallel
   always_comb begin
      prefix_ok = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (CNT_W'(i) < held_count_ff && CNT_W'(i) < plen &&
             held_ff[i] != old_pattern_ff[8*i +: 8]) begin
            prefix_ok = 1'b0;
         end
      end
   end

   // Held buffer: append at the fill position, shift out the front
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         held_in[i] = held_ff[i];
      end
      if (cmd.emit_front) begin
         for (int i = 0; i < MAX_PATTERN - 1; i++) begin
            held_in[i] = held_ff[i+1];
         end
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (cmd.load && held_count_ff == CNT_W'(i)) held_in[i] = req_tdata;
      end
   end

   always_comb begin
      held_count_in = held_count_ff;
      rep_idx_in    = rep_idx_ff;
      total_in      = total_ff;
      end_in        = end_ff;
      if (csr_hit) begin
         held_count_in = '0;
      end else if (cmd.load) begin
         held_count_in = held_count_ff + CNT_W'(1);
      end else if (cmd.emit_front) begin
         held_count_in = held_count_ff - CNT_W'(1);
      end else if (cmd.finish_match || cmd.emit_close) begin
         held_count_in = '0;
      end
      if (cmd.load) end_in = req_tlast;
      if (cmd.emit_rep) rep_idx_in = rep_idx_ff + CNT_W'(1);
      if (cmd.finish_match) begin
         rep_idx_in = '0;
         if (total_ff != 16'hFFFF) total_in = total_ff + 16'd1;
      end
      if (cmd.emit_close) total_in = '0;
   end

   // Output register
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit     = cmd.emit_front || cmd.emit_rep || cmd.emit_close;

   always_comb begin
      rsp_valid_in  = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      if (emit) begin
         rsp_bvalid_in = !cmd.emit_close;
         rsp_last_in   = cmd.emit_close;
         rsp_count_in  = cmd.emit_close ? total_ff : 16'd0;
         if (cmd.emit_front) begin
            rsp_byte_in = held_ff[0];
         end else if (cmd.emit_rep) begin
            rsp_byte_in = byte_at(new_pattern_ff, 3'(rep_idx_ff));
         end else begin
            rsp_byte_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         old_pattern_ff <= '0;
         old_length_ff  <= 4'd1;
         new_pattern_ff <= '0;
         new_length_ff  <= '0;
         held_count_ff  <= '0;
         rep_idx_ff     <= '0;
         total_ff       <= '0;
         end_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         old_pattern_ff <= old_pattern_in;
         old_length_ff  <= old_length_in;
         new_pattern_ff <= new_pattern_in;
         new_length_ff  <= new_length_in;
         held_count_ff  <= held_count_in;
         rep_idx_ff     <= rep_idx_in;
         total_ff       <= total_in;
         end_ff         <= end_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         held_ff[i] <= held_in[i];
      end
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign sts.prefix_ok  = prefix_ok;
   assign sts.full_match = held_count_ff >= plen;
   assign sts.held_empty = held_count_ff == '0;
   assign sts.held_full  = held_count_ff == MAX_CNT;
   assign sts.end_flag   = end_ff;
   assign sts.rep_done   = rep_idx_ff == rlen;
   assign sts.out_free   = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_bvalid_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/substring_find_replace_top.sv
// Top level of the substring find and replace block: controller plus datapath.
// Depends on sfr_pkg, sfr_ctrl, sfr_dpath and the assertion macro header.
//
// Streams text one byte per input item and replaces every leftmost,
// non-overlapping occurrence of a pattern of 1 to MAX_PATTERN bytes with a
// replacement of 0 to MAX_PATTERN bytes. Bytes that may still start a match
// are held back; on a mismatch they are released oldest first until the rest
// is again a pattern prefix. An item with tlast set closes the text: the held
// bytes are flushed and one closing item follows, with byte_valid low, tlast
// high and the saturating match count. Each input byte is accepted and then
// compared, and held bytes that no longer start a match are released one by
// one; a match emits the replacement bytes and then drops the matched bytes,
// and the end of text flushes the held bytes before the closing item. All
// results leave through one output register, one byte per cycle when not stalled.
// Input is taken only when the controller waits for a byte; a finished result
// may still sit in the output register then. Configuration writes are taken
// in any cycle, always ready, and drop any held bytes; issue them only while
// the block is idle. Indexes beyond the register list are ignored.
`default_nettype none
`include "substring_find_replace_top_macros.svh"

module substring_find_replace_top #(
   parameter int unsigned MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // text_end
   // Result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [23:8] match_count
   output logic [0:0]  rsp_tuser,   // [0] byte_valid
   output logic        rsp_tlast,   // run_last
   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [63:0] csr_data
);
   import sfr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequence compare, release, replace and flush steps
   sfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Hold bytes, registers, counters and the output register
   sfr_dpath #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A byte is compared before the next one is taken
   `SFR_ASSERT_NEXT(a_one_byte_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   // The held buffer always has room when a byte arrives
   `SFR_ASSERT_IMP(a_room_on_accept, clock, reset, req_tvalid && req_tready, !sts.held_full)
   // The closing item never carries a text byte
   `SFR_ASSERT_IMP(a_close_no_byte, clock, reset, rsp_tvalid && rsp_tlast, !rsp_tuser[0])
   // Never emit into an occupied, stalled output register
   `SFR_ASSERT_IMP(a_no_overwrite, clock, reset,
      cmd.emit_front || cmd.emit_rep || cmd.emit_close, !rsp_tvalid || rsp_tready)

endmodule

`default_nettype wire
